### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, muted during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk_i edge outside reset
`define MWD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle
`define MWD_ASSERT_NEXT(label, ante, cons, msg) \
  `MWD_ASSERT(label, (ante) |=> (cons), msg)

`endif

### rtl/mwd_pkg.sv
// ----------------------------------------------------------------------------
// mwd_pkg
// Codes, register widths and reset values of the min/max waveform decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package mwd_pkg;

  // Item field widths
  localparam int ACTION_W   = 2;
  localparam int CHANNEL_W  = 3;
  localparam int POSITION_W = 10;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register widths and reset values
  localparam int SPB_W    = 16;
  localparam int LEVELS_W = 11;
  localparam int CHANS_W  = 4;
  localparam logic [SPB_W-1:0]    SPB_RESET    = 16'd256;
  localparam logic [LEVELS_W-1:0] LEVELS_RESET = 11'd1024;
  localparam logic [CHANS_W-1:0]  CHANS_RESET  = 4'd8;

  // Item actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPB      = 2'd0,
    CFG_LEVELS   = 2'd1,
    CFG_CHANNELS = 2'd2
  } cfg_idx_e;

  // Read path sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_DATA
  } state_e;

endpackage

`default_nettype wire

### rtl/mwd_rem.sv
// ----------------------------------------------------------------------------
// mwd_rem
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mwd_rem #(
  parameter int DIVIDEND_W = 11,
  parameter int DIVISOR_W  = 11,
  parameter int REM_W      = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [REM_W-1:0]      rem_o
);

  localparam int CntW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CntW-1:0]       cnt_q;
  logic [DIVIDEND_W-1:0] num_q;
  logic [DIVISOR_W-1:0]  den_q;
  logic [DIVISOR_W-1:0]  rem_q;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic [DIVISOR_W-1:0]  rem_d;

  // Shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, num_q[DIVIDEND_W-1]};
    diff  = trial - {1'b0, den_q};
    if (trial >= {1'b0, den_q}) begin
      rem_d = diff[DIVISOR_W-1:0];
    end else begin
      rem_d = trial[DIVISOR_W-1:0];
    end
  end

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DIVIDEND_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - CntW'(1);
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIVIDEND_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[REM_W-1:0];

endmodule

`default_nettype wire

### rtl/minmax_waveform_decimator_unit.sv
// ----------------------------------------------------------------------------
// minmax_waveform_decimator_unit
// Per-channel min/max decimator feeding a ring of stored levels per channel.
// ----------------------------------------------------------------------------
// A push or clear updates channel state on acceptance; a push never stalls the
// input. A read runs the bit-serial modulo over SumW bits (SumW = 11 at default
// depth), registers the row and loads the result register; input reopens once
// the result is loaded. Reset, a clear item and a channels_in_use write sweep
// the level memory, one row per cycle, with no item accepted meanwhile. A
// levels_in_use write sweeps only the rows from the new ring length up.
// ----------------------------------------------------------------------------
`default_nettype none

module minmax_waveform_decimator_unit #(
  parameter int LEVEL_DEPTH   = 1024,
  parameter int CHANNEL_COUNT = 8,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input items
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // channel, sample, position (from bit 0 up), zero padded to bytes
  input  logic [((mwd_pkg::CHANNEL_W + SAMPLE_BITS + mwd_pkg::POSITION_W + 7) / 8) * 8 - 1:0]
                                                s_axis_tdata,
  // action
  input  logic [mwd_pkg::ACTION_W-1:0]          s_axis_tuser,
  // Result items
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // level_min, level_max (from bit 0 up), zero padded to bytes
  output logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // Configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mwd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mwd_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  import mwd_pkg::*;

  localparam int OutW = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int LevW = 2 * SAMPLE_BITS;
  localparam int RowW = $clog2(LEVEL_DEPTH);
  localparam int LenW = $clog2(LEVEL_DEPTH + 1);
  localparam int ChW  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int SumW = $clog2(LEVEL_DEPTH + (1 << POSITION_W) - 1);
  localparam int CmpW = (LenW > LEVELS_W) ? LenW : LEVELS_W;

  // Ring length clamped to 1..LEVEL_DEPTH
  function automatic logic [LenW-1:0] clamp_len(input logic [LEVELS_W-1:0] v);
    logic [CmpW-1:0] vx;
    vx = CmpW'(v);
    if (v == '0) begin
      return LenW'(1);
    end else if (vx > CmpW'(LEVEL_DEPTH)) begin
      return LenW'(LEVEL_DEPTH);
    end else begin
      return LenW'(vx);
    end
  endfunction

  // Item fields
  logic [CHANNEL_W-1:0]          ch_in;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [POSITION_W-1:0]         pos_in;
  action_e                       act_in;

  assign ch_in     = s_axis_tdata[CHANNEL_W-1:0];
  assign sample_in = $signed(s_axis_tdata[CHANNEL_W +: SAMPLE_BITS]);
  assign pos_in    = s_axis_tdata[CHANNEL_W + SAMPLE_BITS +: POSITION_W];
  assign act_in    = action_e'(s_axis_tuser);

  // Configuration registers
  logic [SPB_W-1:0]    spb_q;
  logic [LEVELS_W-1:0] levels_q;
  logic [CHANS_W-1:0]  chans_q;

  // Per-channel state
  logic [RowW-1:0]               wp_q   [CHANNEL_COUNT];
  logic [SPB_W-1:0]              cnt_q  [CHANNEL_COUNT];
  logic signed [SAMPLE_BITS-1:0] rmin_q [CHANNEL_COUNT];
  logic signed [SAMPLE_BITS-1:0] rmax_q [CHANNEL_COUNT];

  // Level memory: one row per ring slot, one lane per channel ({max, min})
  logic [CHANNEL_COUNT-1:0][LevW-1:0] mem_q [LEVEL_DEPTH];
  logic [CHANNEL_COUNT-1:0][LevW-1:0] rd_row_q;

  // Clearing sweep
  logic            sweep_q;
  logic [RowW-1:0] sweep_row_q;

  // Read path
  state_e          state_q, state_d;
  logic            ch_ok_q;
  logic [ChW-1:0]  lane_q;
  logic            out_valid_q;
  logic [LevW-1:0] out_data_q;

  logic            in_acc;
  logic            cfg_acc;
  logic            ch_ok;
  logic [ChW-1:0]  ch_idx;
  logic            push_ok;
  logic            rd_start;
  logic            clear_all;
  logic            cfg_lev_wr;
  logic [LenW-1:0] len_cur;
  logic [LenW-1:0] len_new;
  logic            sweep_req;
  logic [RowW-1:0] sweep_start;
  logic [RowW-1:0] wp_sel;
  logic [LenW-1:0] wp_plus;
  logic [RowW-1:0] wp_new;
  logic            expire;
  logic            lvl_we;
  logic [SumW-1:0] dividend;
  logic            rem_done;
  logic [RowW-1:0] rem_row;
  logic            rd_en;
  logic            out_load;
  logic [LevW-1:0] rd_lane;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;
  assign in_acc      = s_axis_tvalid && s_axis_tready;

  assign len_cur = clamp_len(levels_q);
  assign len_new = clamp_len(cfg_data_i[LEVELS_W-1:0]);

  // Item decode
  assign ch_ok     = int'(ch_in) < CHANNEL_COUNT;
  assign ch_idx    = ChW'(ch_in);
  assign push_ok   = in_acc && (act_in == ACT_PUSH) && ch_ok
                     && ({1'b0, ch_in} < chans_q);
  assign rd_start  = in_acc && (act_in == ACT_READ);
  assign cfg_lev_wr = cfg_acc && (cfg_idx_e'(cfg_index_i) == CFG_LEVELS);
  assign clear_all = (in_acc && (act_in == ACT_CLEAR))
                     || (cfg_acc && (cfg_idx_e'(cfg_index_i) == CFG_CHANNELS));

  // Write pointer advance with wrap at the ring length
  assign wp_sel  = ch_ok ? wp_q[ch_idx] : '0;
  assign wp_plus = LenW'(wp_sel) + LenW'(1);
  assign wp_new  = (wp_plus >= len_cur) ? '0 : RowW'(wp_plus);
  assign expire  = ch_ok && (cnt_q[ch_idx] <= SPB_W'(1));
  assign lvl_we  = push_ok && expire;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q    <= SPB_RESET;
      levels_q <= LEVELS_RESET;
      chans_q  <= CHANS_RESET;
    end else if (cfg_acc) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SPB:      spb_q    <= cfg_data_i[SPB_W-1:0];
        CFG_LEVELS:   levels_q <= cfg_data_i[LEVELS_W-1:0];
        CFG_CHANNELS: chans_q  <= cfg_data_i[CHANS_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-channel counters and running ranges
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        wp_q[c]   <= '0;
        cnt_q[c]  <= '0;
        rmin_q[c] <= '0;
        rmax_q[c] <= '0;
      end
    end else if (clear_all) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        wp_q[c]   <= '0;
        cnt_q[c]  <= '0;
        rmin_q[c] <= '0;
        rmax_q[c] <= '0;
      end
    end else if (cfg_lev_wr) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        if (LenW'(wp_q[c]) >= len_new) begin
          wp_q[c] <= '0;
        end
      end
    end else if (push_ok) begin
      if (expire) begin
        wp_q[ch_idx]   <= wp_new;
        cnt_q[ch_idx]  <= spb_q;
        rmin_q[ch_idx] <= sample_in;
        rmax_q[ch_idx] <= sample_in;
      end else begin
        cnt_q[ch_idx] <= cnt_q[ch_idx] - SPB_W'(1);
        if (sample_in < rmin_q[ch_idx]) begin
          rmin_q[ch_idx] <= sample_in;
        end
        if (sample_in > rmax_q[ch_idx]) begin
          rmax_q[ch_idx] <= sample_in;
        end
      end
    end
  end

  // Sweep request: whole memory on a clear, tail rows on a shorter ring
  assign sweep_req   = clear_all || (cfg_lev_wr && (len_new < LenW'(LEVEL_DEPTH)));
  assign sweep_start = clear_all ? '0 : RowW'(len_new);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      sweep_row_q <= '0;
    end else if (sweep_req) begin
      sweep_q <= 1'b1;
      if (!sweep_q || (sweep_start < sweep_row_q)) begin
        sweep_row_q <= sweep_start;
      end
    end else if (sweep_q) begin
      if (sweep_row_q == RowW'(LEVEL_DEPTH - 1)) begin
        sweep_q <= 1'b0;
      end else begin
        sweep_row_q <= sweep_row_q + RowW'(1);
      end
    end
  end

  // Level memory: sweep or push write, registered row read
  always_ff @(posedge clk_i) begin
    if (sweep_q) begin
      mem_q[sweep_row_q] <= '0;
    end else if (lvl_we) begin
      mem_q[wp_new][ch_idx] <= {rmax_q[ch_idx], rmin_q[ch_idx]};
    end
    if (rd_en) begin
      rd_row_q <= mem_q[rem_row];
    end
  end

  // Read slot = (write pointer + position) mod ring length
  assign dividend = SumW'(wp_sel) + SumW'(pos_in);

  mwd_rem #(
    .DIVIDEND_W (SumW),
    .DIVISOR_W  (LenW),
    .REM_W      (RowW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rd_start),
    .dividend_i (dividend),
    .divisor_i  (len_cur),
    .done_o     (rem_done),
    .rem_o      (rem_row)
  );

  // Read item context
  always_ff @(posedge clk_i) begin
    if (rd_start) begin
      ch_ok_q <= ch_ok;
      lane_q  <= ch_idx;
    end
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (rd_start) state_d = ST_MOD;
      ST_MOD:  if (rem_done) state_d = ST_DATA;
      ST_DATA: if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = !sweep_q;
      ST_MOD:  rd_en = rem_done;
      ST_DATA: out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Result register
  assign rd_lane = ch_ok_q ? rd_row_q[lane_q] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= rd_lane;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(out_data_q);

endmodule

`default_nettype wire

### rtl/mwd_checker.sv
// ----------------------------------------------------------------------------
// mwd_checker
// Port-level checks of the min/max waveform decimator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mwd_checker #(
  parameter int OUT_W = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [mwd_pkg::ACTION_W-1:0] s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [OUT_W-1:0]             m_axis_tdata,
  input logic                         cfg_valid_i
);

  import mwd_pkg::*;

  logic push_acc;
  logic read_acc;
  logic clear_acc;

  assign push_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_PUSH);
  assign read_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_READ);
  assign clear_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_CLEAR);

  // A stalled result stays offered
  `MWD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")

  // A stalled result keeps its value
  `MWD_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed")

  // A read occupies the modulo unit, so no item follows at once
  `MWD_ASSERT_NEXT(a_read_busy, read_acc, !s_axis_tready, "item taken during read")

  // A clear starts the memory sweep
  `MWD_ASSERT_NEXT(a_clear_busy, clear_acc, !s_axis_tready, "item taken during clear")

  // A push completes on acceptance and does not stall the input
  `MWD_ASSERT_NEXT(a_push_free, push_acc && !cfg_valid_i, s_axis_tready, "push stalled input")

endmodule

bind minmax_waveform_decimator_unit mwd_checker #(
  .OUT_W (OutW)
) u_mwd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i)
);

`default_nettype wire
